// File: rtl/efr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efr_pkg
// Shared types and constants for the escaped frame receiver.
// ----------------------------------------------------------------------------
package efr_pkg;

  // Upper bound on the number of decoded payload bytes in one frame
  localparam logic [6:0] MAX_PAYLOAD = 7'd64;

  // Special byte values on the link
  localparam logic [7:0] FRAME_END   = 8'd255;
  localparam logic [7:0] ESC_BYTE    = 8'd27;
  localparam logic [7:0] ESC_FOR_ESC = 8'd28;
  localparam logic [7:0] ESC_FOR_END = 8'd29;

  // Configuration register indexes (byte address bit 2)
  localparam logic REG_KNOWN_TYPE  = 1'b0;
  localparam logic REG_PAYLOAD_LEN = 1'b1;

  typedef enum logic [2:0] {
    ST_WAIT_TYPE  = 3'd0,
    ST_RECEIVING  = 3'd1,
    ST_ESCAPED    = 3'd2,
    ST_EXPECT_END = 3'd3,
    ST_ERROR_WAIT = 3'd4
  } efr_state_e;

  typedef enum logic [2:0] {
    CODE_SUCCESS        = 3'd0,
    CODE_GENERIC        = 3'd1,
    CODE_UNKNOWN_TYPE   = 3'd2,
    CODE_ILLEGAL_ESCAPE = 3'd3,
    CODE_MISSED_END     = 3'd4
  } efr_code_e;

  typedef struct packed {
    logic [7:0] known_type;
    logic [6:0] payload_len;
  } efr_cfg_t;

  typedef struct packed {
    logic       is_reply;
    logic [2:0] reply_code;
    logic [7:0] payload_byte;
    logic [5:0] payload_index;
    logic       error_led;
  } efr_result_t;

endpackage
`default_nettype wire

// File: rtl/efr_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efr_cfg_regs
// APB-style register file holding the accepted command type and length.
// ----------------------------------------------------------------------------
module efr_cfg_regs (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output efr_pkg::efr_cfg_t     cfg_o
);
  import efr_pkg::*;

  logic [7:0] known_type_q;
  logic [6:0] payload_len_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_type_q  <= 8'd1;
      payload_len_q <= 7'd4;
    end else if (wr_en) begin
      case (paddr[2])
        REG_KNOWN_TYPE:  known_type_q  <= pwdata[7:0];
        REG_PAYLOAD_LEN: payload_len_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Low address bits select nothing: registers sit on word boundaries
  always_comb begin
    prdata = 32'd0;
    case (paddr[2])
      REG_KNOWN_TYPE:  prdata = {24'd0, known_type_q};
      REG_PAYLOAD_LEN: prdata = {25'd0, payload_len_q};
      default:         prdata = 32'd0;
    endcase
    if (paddr[1:0] != 2'd0) begin
      prdata = 32'd0;
    end
  end

  assign cfg_o.known_type  = known_type_q;
  assign cfg_o.payload_len = payload_len_q;

endmodule
`default_nettype wire

// File: rtl/efr_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efr_parser
// Frame state machine: decodes one received byte per accepted request.
// ----------------------------------------------------------------------------
module efr_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire efr_pkg::efr_cfg_t cfg_i,
  input  wire logic              accept_i,
  input  wire logic [7:0]        rx_byte_i,
  output logic                   res_valid_o,
  output efr_pkg::efr_result_t   res_o
);
  import efr_pkg::*;

  efr_state_e state_q, state_d;
  logic [6:0] pos_q, pos_d;
  logic [2:0] err_q, err_d;
  logic       led_q, led_d;

  logic [6:0] frame_len;
  logic [6:0] pos_inc;
  logic       do_store;
  logic [7:0] store_val;
  logic       has_res;

  assign frame_len = (cfg_i.payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : cfg_i.payload_len;
  assign pos_inc   = pos_q + 7'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WAIT_TYPE;
      pos_q   <= 7'd0;
      err_q   <= CODE_GENERIC;
      led_q   <= 1'b0;
    end else if (accept_i) begin
      state_q <= state_d;
      pos_q   <= pos_d;
      err_q   <= err_d;
      led_q   <= led_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    err_d     = err_q;
    led_d     = led_q;
    do_store  = 1'b0;
    store_val = rx_byte_i;
    has_res   = 1'b0;
    res_o     = '0;

    if (rx_byte_i == FRAME_END && state_q != ST_EXPECT_END) begin
      // abort: report the last error and drop the frame
      state_d          = ST_WAIT_TYPE;
      led_d            = 1'b0;
      has_res          = 1'b1;
      res_o.is_reply   = 1'b1;
      res_o.reply_code = err_q;
    end else begin
      case (state_q)
        ST_RECEIVING: begin
          if (rx_byte_i == ESC_BYTE) begin
            state_d = ST_ESCAPED;
          end else begin
            do_store = 1'b1;
          end
        end
        ST_ESCAPED: begin
          if (rx_byte_i == ESC_FOR_ESC) begin
            do_store  = 1'b1;
            store_val = ESC_BYTE;
          end else if (rx_byte_i == ESC_FOR_END) begin
            do_store  = 1'b1;
            store_val = FRAME_END;
          end else begin
            state_d = ST_ERROR_WAIT;
            led_d   = 1'b1;
            err_d   = CODE_ILLEGAL_ESCAPE;
          end
        end
        ST_EXPECT_END: begin
          if (rx_byte_i == FRAME_END) begin
            state_d          = ST_WAIT_TYPE;
            has_res          = 1'b1;
            res_o.is_reply   = 1'b1;
            res_o.reply_code = CODE_SUCCESS;
          end else begin
            state_d = ST_ERROR_WAIT;
            led_d   = 1'b1;
            err_d   = CODE_MISSED_END;
          end
        end
        ST_ERROR_WAIT: ;
        default: begin
          // waiting for the command type; unused codes land here too
          pos_d = 7'd0;
          if (rx_byte_i != cfg_i.known_type || frame_len == 7'd0) begin
            state_d = ST_ERROR_WAIT;
            led_d   = 1'b1;
            err_d   = CODE_UNKNOWN_TYPE;
          end else begin
            state_d = ST_RECEIVING;
          end
        end
      endcase

      if (do_store) begin
        pos_d               = pos_inc;
        state_d             = (pos_inc >= frame_len) ? ST_EXPECT_END : ST_RECEIVING;
        has_res             = 1'b1;
        res_o.payload_byte  = store_val;
        res_o.payload_index = pos_q[5:0];
      end
    end

    res_o.error_led = led_d;
  end

  assign res_valid_o = accept_i & has_res;

endmodule
`default_nettype wire

// File: rtl/efr_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efr_out_queue
// Two-entry result buffer between the parser and the output channel.
// ----------------------------------------------------------------------------
module efr_out_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire efr_pkg::efr_result_t push_data_i,
  output logic                      full_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output efr_pkg::efr_result_t      out_data_o
);
  import efr_pkg::*;

  efr_result_t mem_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  count_q, count_d;
  logic        pop;

  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign pop         = out_valid_o & out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({push_i, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/escaped_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_frame_receiver
// Byte-stuffed frame receiver: command type, escaped payload, terminator.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  rx        in         in_valid_i / in_ready_o    rx_byte_i
//  result    out        out_valid_o / out_ready_i  is_reply_o, reply_code_o,
//                                                 payload_byte_o, payload_index_o,
//                                                 error_led_o
//  config    in         psel/penable/pwrite        paddr, pwdata, prdata, pready
//
//  One byte per cycle while in_ready_o is high: the parser state updates in
//  the cycle a request is taken and any result is written to a two-entry
//  queue on that edge, whose head drives the output. in_ready_o falls only
//  while both queue entries hold untaken results. Reset brings the parser to
//  waiting for a command type, last error to generic, LED off, queue empty.
// ----------------------------------------------------------------------------
module escaped_frame_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             is_reply_o,
  output logic [2:0]       reply_code_o,
  output logic [7:0]       payload_byte_o,
  output logic [5:0]       payload_index_o,
  output logic             error_led_o
);
  import efr_pkg::*;

  efr_cfg_t    cfg;
  efr_result_t res;
  efr_result_t head;
  logic        res_valid;
  logic        full;
  logic        accept;

  assign in_ready_o = ~full;
  assign accept     = in_valid_i & ~full;

  efr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  efr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  efr_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (head)
  );

  assign is_reply_o      = head.is_reply;
  assign reply_code_o    = head.reply_code;
  assign payload_byte_o  = head.payload_byte;
  assign payload_index_o = head.payload_index;
  assign error_led_o     = head.error_led;

endmodule
`default_nettype wire

// File: verif/tb_escaped_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escaped_frame_receiver
// Self-checking bench for the byte-stuffed frame receiver. A behavioural
// parser in the bench tracks every accepted byte and queues the replies and
// decoded payload bytes it should produce. A monitor pops and compares each
// result field by field. The run covers directed frames, a sweep of the
// configuration registers, a long output hold-off and random frame traffic
// under several idling patterns.
// ----------------------------------------------------------------------------
module tb_escaped_frame_receiver;
  import efr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        is_reply;
  logic [2:0]  reply_code;
  logic [7:0]  payload_byte;
  logic [5:0]  payload_index;
  logic        error_led;

  // Bench copy of the parser
  efr_cfg_t    cfg;
  efr_state_e  rx_state;
  logic [6:0]  rx_pos;
  efr_code_e   rx_last_err;
  logic        rx_led;
  efr_result_t parser_out_q[$];

  int unsigned rx_gap_pct = 0;
  int unsigned stall_pct = 0;
  int          hold_left = 0;
  int          bytes_sent = 0;
  int          errors = 0;
  int          cycle_count = 0;

  escaped_frame_receiver dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .is_reply_o     (is_reply),
    .reply_code_o   (reply_code),
    .payload_byte_o (payload_byte),
    .payload_index_o(payload_index),
    .error_led_o    (error_led)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: a long hold-off when requested, otherwise random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    efr_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (parser_out_q.size() == 0) begin
        $display("%0t: unexpected result is_reply=%0d code=%0d byte=%0d index=%0d led=%0d",
                 $realtime, is_reply, reply_code, payload_byte, payload_index, error_led);
        errors++;
      end else begin
        want = parser_out_q.pop_front();
        if (is_reply !== want.is_reply) begin
          $display("%0t: is_reply expected %0d got %0d", $realtime, want.is_reply, is_reply);
          errors++;
        end
        if (reply_code !== want.reply_code) begin
          $display("%0t: reply_code expected %0d got %0d", $realtime, want.reply_code,
                   reply_code);
          errors++;
        end
        if (payload_byte !== want.payload_byte) begin
          $display("%0t: payload_byte expected %0d got %0d", $realtime, want.payload_byte,
                   payload_byte);
          errors++;
        end
        if (payload_index !== want.payload_index) begin
          $display("%0t: payload_index expected %0d got %0d", $realtime, want.payload_index,
                   payload_index);
          errors++;
        end
        if (error_led !== want.error_led) begin
          $display("%0t: error_led expected %0d got %0d", $realtime, want.error_led,
                   error_led);
          errors++;
        end
      end
    end
  end

  // Effective payload length, saturated at the maximum
  function automatic logic [6:0] frame_len();
    return (cfg.payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : cfg.payload_len;
  endfunction

  function automatic efr_result_t take_payload(input logic [7:0] value);
    efr_result_t r;
    r = '0;
    r.payload_byte  = value;
    r.payload_index = rx_pos[5:0];
    rx_pos   = rx_pos + 7'd1;
    rx_state = (rx_pos >= frame_len()) ? ST_EXPECT_END : ST_RECEIVING;
    return r;
  endfunction

  task automatic raise_error(input efr_code_e code);
    rx_led      = 1'b1;
    rx_state    = ST_ERROR_WAIT;
    rx_last_err = code;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    efr_result_t r;
    bit          emit;
    r    = '0;
    emit = 1'b0;
    if (b == FRAME_END && rx_state != ST_EXPECT_END) begin
      // abort: reply with the last error and clear the LED
      rx_state     = ST_WAIT_TYPE;
      rx_led       = 1'b0;
      r.is_reply   = 1'b1;
      r.reply_code = rx_last_err;
      emit         = 1'b1;
    end else begin
      case (rx_state)
        ST_RECEIVING: begin
          if (b == ESC_BYTE) begin
            rx_state = ST_ESCAPED;
          end else begin
            r    = take_payload(b);
            emit = 1'b1;
          end
        end
        ST_ESCAPED: begin
          if (b == ESC_FOR_ESC) begin
            r    = take_payload(ESC_BYTE);
            emit = 1'b1;
          end else if (b == ESC_FOR_END) begin
            r    = take_payload(FRAME_END);
            emit = 1'b1;
          end else begin
            raise_error(CODE_ILLEGAL_ESCAPE);
          end
        end
        ST_EXPECT_END: begin
          if (b == FRAME_END) begin
            rx_state     = ST_WAIT_TYPE;
            r.is_reply   = 1'b1;
            r.reply_code = CODE_SUCCESS;
            emit         = 1'b1;
          end else begin
            raise_error(CODE_MISSED_END);
          end
        end
        ST_ERROR_WAIT: ;
        default: begin
          rx_pos = '0;
          if (b != cfg.known_type || frame_len() == 7'd0) raise_error(CODE_UNKNOWN_TYPE);
          else rx_state = ST_RECEIVING;
        end
      endcase
    end
    if (emit) begin
      r.error_led = rx_led;
      parser_out_q.push_back(r);
    end
  endtask

  // Offer one byte; entered and left just after a rising edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < rx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  // Drop valid and hold until every predicted result has been taken
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (parser_out_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] known_type, input logic [6:0] len);
    wait_idle();
    write_reg(REG_KNOWN_TYPE, {24'd0, known_type});
    write_reg(REG_PAYLOAD_LEN, {25'd0, len});
    cfg.known_type  = known_type;
    cfg.payload_len = len;
  endtask

  // Build one escaped frame for the current setting, optionally damaged
  task automatic send_frame(input bit mangle);
    logic [7:0] line_q[$];
    logic [7:0] v;
    int         k;
    line_q.push_back(cfg.known_type);
    for (int i = 0; i < int'(frame_len()); i++) begin
      case ($urandom_range(0, 9))
        0:       v = ESC_BYTE;
        1:       v = FRAME_END;
        default: v = 8'($urandom_range(0, 255));
      endcase
      if (v == ESC_BYTE) begin
        line_q.push_back(ESC_BYTE);
        line_q.push_back(ESC_FOR_ESC);
      end else if (v == FRAME_END) begin
        line_q.push_back(ESC_BYTE);
        line_q.push_back(ESC_FOR_END);
      end else begin
        line_q.push_back(v);
      end
    end
    line_q.push_back(FRAME_END);
    if (mangle) begin
      k = $urandom_range(0, line_q.size() - 1);
      case ($urandom_range(0, 4))
        0: line_q[k] = 8'($urandom_range(0, 255));
        1: line_q.insert(k, 8'($urandom_range(0, 255)));
        2: begin
          // cut short and close early
          while (line_q.size() > k + 1) void'(line_q.pop_back());
          line_q.push_back(FRAME_END);
        end
        3: line_q[0] = 8'($urandom_range(0, 255));
        default: begin
          line_q.insert(k, 8'($urandom_range(0, 255)));
          line_q.insert(k, ESC_BYTE);
        end
      endcase
    end
    foreach (line_q[j]) send_byte(line_q[j]);
  endtask

  task automatic test_directed();
    logic [7:0] seq[] = '{
      FRAME_END,
      8'd1, 8'd0, ESC_BYTE, ESC_FOR_ESC, 8'd254, ESC_BYTE, ESC_FOR_END, FRAME_END,
      8'd7, 8'd5, FRAME_END,
      8'd1, ESC_BYTE, 8'd30, FRAME_END,
      8'd1, 8'd1, 8'd2, 8'd3, 8'd4, 8'd0, FRAME_END,
      8'd1, FRAME_END
    };
    rx_gap_pct = 0;
    stall_pct  = 0;
    foreach (seq[i]) send_byte(seq[i]);
    wait_idle();
  endtask

  task automatic test_config_sweep();
    logic [7:0] types[] = '{8'd0, 8'd254, 8'd255, 8'd9, 8'd42, 8'd77};
    logic [6:0] lens[]  = '{7'd1, 7'd64, 7'd5, 7'd0, 7'd127, 7'd3};
    rx_gap_pct = 15;
    stall_pct  = 15;
    foreach (types[i]) begin
      set_config(types[i], lens[i]);
      send_frame(1'b0);
      send_frame(1'b0);
      send_frame(1'b1);
    end
    wait_idle();
  endtask

  task automatic test_output_holdoff();
    set_config(8'd3, 7'd20);
    rx_gap_pct = 0;
    stall_pct  = 0;
    hold_left  = 80;
    repeat (3) send_frame(1'b0);
    wait_idle();
    send_frame(1'b0);
    wait_idle();
  endtask

  task automatic test_random_phase(input int unsigned gap, input int unsigned stall,
                                   input int n_bytes);
    int target;
    int next_cfg;
    rx_gap_pct = gap;
    stall_pct  = stall;
    target     = bytes_sent + n_bytes;
    next_cfg   = bytes_sent;
    while (bytes_sent < target) begin
      if (bytes_sent >= next_cfg) begin
        set_config(8'($urandom_range(0, 254)),
                   ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                               : 7'($urandom_range(1, 8)));
        next_cfg = bytes_sent + 120;
      end
      case ($urandom_range(0, 9))
        7, 8:    send_frame(1'b1);
        9:       repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        default: send_frame(1'b0);
      endcase
    end
    wait_idle();
  endtask

  initial begin
    cfg.known_type  = 8'd1;
    cfg.payload_len = 7'd4;
    rx_state        = ST_WAIT_TYPE;
    rx_pos          = '0;
    rx_last_err     = CODE_GENERIC;
    rx_led          = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_config_sweep();
    test_output_holdoff();
    test_random_phase(0, 0, 200);
    test_random_phase(49, 0, 200);
    test_random_phase(0, 49, 200);
    test_random_phase(15, 15, 200);

    wait_idle();
    repeat (20) @(posedge clk);
    if (parser_out_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, parser_out_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
